// ----- hdl/rgb_bilinear_resampler_macros.svh -----
// Assertion macros shared by the resampler checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef RGB_BILINEAR_RESAMPLER_MACROS_SVH
`define RGB_BILINEAR_RESAMPLER_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define BILR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define BILR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/bilr_pkg.sv -----
// Shared types and constants of the RGB bilinear resampler.
// Depends on nothing; used by every module of the block.
package bilr_pkg;

	localparam int CFG_W   = 16;
	localparam int SRC_W   = 9;
	localparam int TGT_W   = 16;
	localparam int COORD_W = 16;
	localparam int IDX_W   = 16;
	localparam int NUM_W   = COORD_W + SRC_W;
	localparam int PIX_W   = 24;

	localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
	localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [IDX_W-1:0]   pixel_index;
		logic [7:0]         in_red;
		logic [7:0]         in_green;
		logic [7:0]         in_blue;
		logic [COORD_W-1:0] target_x;
		logic [COORD_W-1:0] target_y;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       bad_request;
	} out_item_t;

	// Control and load payload that rides along the arithmetic pipeline.
	typedef struct packed {
		logic             vld;
		logic             cmp;
		logic             bad;
		logic [IDX_W-1:0] pixel_index;
		logic [PIX_W-1:0] rgb;
	} side_t;

endpackage

// ----- hdl/rgb_bilinear_resampler.sv -----
// Top level of the RGB bilinear resampler: source store, address and weight stages.
// Depends on bilr_pkg and bilr_div_pipe.
//
// The block holds an interleaved RGB8 source image and answers one item per
// clock. A load item writes one source pixel at its raster index; a compute item
// returns the bilinearly resampled RGB of one destination pixel. Sample positions
// are index*source/target per axis with no centre offset, taken as an integer
// part and a FRACTION_BITS fraction. The right and lower neighbours are the next
// pixel in raster order and the pixel one source row further on; a neighbour past
// the last stored pixel reads that pixel's blue byte on all three channels, which
// is how the flat byte clamp behaves. A request outside the target size returns
// bad_request with zero colors. Throughput is one item per clock at any mix of
// loads and computes while the output is not stalled. Each item passes the
// scaling stage, then the bit-per-stage divider that forms the sample positions,
// then the address, weight, read, product and sum stages. The source store is
// kept in two identical copies, each read at two addresses per clock, so the four
// neighbours of a pixel come out in one read. The store needs no clearing: pixels
// that were never loaded read as anything. Configuration writes belong to idle
// periods; when the output stalls, the whole pipeline holds and the input stalls.
module rgb_bilinear_resampler #(
	parameter int MAX_SOURCE_DIM    = 256,
	parameter int MAX_SOURCE_PIXELS = 65536,
	parameter int FRACTION_BITS     = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  bilr_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output bilr_pkg::out_item_t        out_data,
	input  logic                       wr_en,
	input  logic [1:0]                 wr_index,
	input  logic [bilr_pkg::CFG_W-1:0] wr_data
);

	localparam int SW  = bilr_pkg::SRC_W;
	localparam int TW  = bilr_pkg::TGT_W;
	localparam int F   = FRACTION_BITS;
	localparam int WI  = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM) : 1;
	localparam int QW  = WI + F;
	localparam int AW  = $clog2(MAX_SOURCE_PIXELS);
	// Linear pixel addresses before clamping, and the pixel count of the image.
	localparam int LW  = (WI + SW + 1 > 2 * SW) ? WI + SW + 1 : 2 * SW;
	localparam int WW  = 2 * F + 2;
	localparam int PW  = WW + 8;
	localparam int ACW = 2 * F + 8;
	localparam int PXW = bilr_pkg::PIX_W;

	// Configuration registers.
	logic [SW-1:0] src_w_q;
	logic [SW-1:0] src_h_q;
	logic [TW-1:0] tgt_w_q;
	logic [TW-1:0] tgt_h_q;
	logic [LW-1:0] last_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SW'(1);
			src_h_q <= SW'(1);
			tgt_w_q <= TW'(1);
			tgt_h_q <= TW'(1);
		end else if (wr_en) begin
			case (wr_index)
				bilr_pkg::REG_SOURCE_WIDTH:  src_w_q <= wr_data[SW-1:0];
				bilr_pkg::REG_SOURCE_HEIGHT: src_h_q <= wr_data[SW-1:0];
				bilr_pkg::REG_TARGET_WIDTH:  tgt_w_q <= wr_data[TW-1:0];
				bilr_pkg::REG_TARGET_HEIGHT: tgt_h_q <= wr_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// Effective sizes: zero acts as one, and the source is capped at its maximum.
	logic [SW-1:0]   eff_sw;
	logic [SW-1:0]   eff_sh;
	logic [TW-1:0]   eff_tw;
	logic [TW-1:0]   eff_th;
	logic [2*SW-1:0] src_area;

	always_comb begin
		eff_sw = (src_w_q == '0) ? SW'(1) : src_w_q;
		if (32'(eff_sw) > MAX_SOURCE_DIM) begin
			eff_sw = SW'(MAX_SOURCE_DIM);
		end
		eff_sh = (src_h_q == '0) ? SW'(1) : src_h_q;
		if (32'(eff_sh) > MAX_SOURCE_DIM) begin
			eff_sh = SW'(MAX_SOURCE_DIM);
		end
		eff_tw = (tgt_w_q == '0) ? TW'(1) : tgt_w_q;
		eff_th = (tgt_h_q == '0) ? TW'(1) : tgt_h_q;
		src_area = eff_sw * eff_sh;
	end

	// The index of the last stored pixel is registered, so it follows the size registers in the cycle after they change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pix_q <= '0;
		end else if (32'(src_area) > MAX_SOURCE_PIXELS) begin
			last_pix_q <= LW'(MAX_SOURCE_PIXELS - 1);
		end else begin
			last_pix_q <= LW'(src_area) - LW'(1);
		end
	end

	// The whole pipeline moves together unless a finished result is held up.
	logic adv;
	logic accept;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// Stage 1: scale the destination coordinates by the source size.
	bilr_pkg::side_t side_s1;
	logic [bilr_pkg::NUM_W-1:0] num_x_s1;
	logic [bilr_pkg::NUM_W-1:0] num_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (adv) begin
			side_s1.vld         <= accept;
			side_s1.cmp         <= in_data.opcode == bilr_pkg::OP_COMPUTE;
			side_s1.bad         <= (in_data.target_x >= eff_tw) || (in_data.target_y >= eff_th);
			side_s1.pixel_index <= in_data.pixel_index;
			side_s1.rgb         <= {in_data.in_red, in_data.in_green, in_data.in_blue};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_x_s1 <= in_data.target_x * eff_sw;
			num_y_s1 <= in_data.target_y * eff_sh;
		end
	end

	// Divider stages: quotient holds the integer part over the fraction.
	bilr_pkg::side_t side_d;
	logic [QW-1:0]   quo_x;
	logic [QW-1:0]   quo_y;

	bilr_div_pipe #(
		.INT_BITS (WI),
		.FRAC_BITS(F)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.num_x   (num_x_s1),
		.num_y   (num_y_s1),
		.den_x   (eff_tw),
		.den_y   (eff_th),
		.side_in (side_s1),
		.side_out(side_d),
		.quo_x   (quo_x),
		.quo_y   (quo_y)
	);

	// Stage 2: linear address of the top-left neighbour.
	bilr_pkg::side_t side_s2;
	logic [LW-1:0]   base_s2;
	logic [F-1:0]    fx_s2;
	logic [F-1:0]    fy_s2;
	logic [WI+SW-1:0] row_off;

	assign row_off = quo_y[QW-1:F] * eff_sw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (adv) begin
			side_s2 <= side_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s2 <= LW'(quo_x[QW-1:F]) + LW'(row_off);
			fx_s2   <= quo_x[F-1:0];
			fy_s2   <= quo_y[F-1:0];
		end
	end

	// Stage 3: four neighbour addresses clamped to the last pixel, and the weights.
	// The weight products are formed at full width, since one minus a zero fraction
	// squared needs a bit above the 2*FRACTION_BITS fraction.
	bilr_pkg::side_t side_s3;
	logic [AW-1:0]   addr_s3 [4];
	logic [3:0]      over_s3;
	logic [WW-1:0]   wgt_s3 [4];
	logic [LW-1:0]   nb_addr [4];
	logic [F:0]      ofx;
	logic [F:0]      ofy;

	always_comb begin
		nb_addr[0] = base_s2;
		nb_addr[1] = base_s2 + LW'(1);
		nb_addr[2] = base_s2 + LW'(eff_sw);
		nb_addr[3] = base_s2 + LW'(eff_sw) + LW'(1);
		ofx = {1'b1, {F{1'b0}}} - (F+1)'(fx_s2);
		ofy = {1'b1, {F{1'b0}}} - (F+1)'(fy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (adv) begin
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				over_s3[k] <= nb_addr[k] > last_pix_q;
				addr_s3[k] <= (nb_addr[k] > last_pix_q) ? AW'(last_pix_q) : AW'(nb_addr[k]);
			end
			wgt_s3[0] <= WW'(ofy) * WW'(ofx);
			wgt_s3[1] <= WW'(ofy) * WW'(fx_s2);
			wgt_s3[2] <= WW'(fy_s2) * WW'(ofx);
			wgt_s3[3] <= WW'(fy_s2) * WW'(fx_s2);
		end
	end

	// Source store, two copies: copy A serves the upper pair, copy B the lower pair.
	// Loads are written here, in order with the reads of the computes around them.
	logic [PXW-1:0] mem_a_q [MAX_SOURCE_PIXELS];
	logic [PXW-1:0] mem_b_q [MAX_SOURCE_PIXELS];
	logic           wr_ok;

	assign wr_ok = adv && side_s3.vld && !side_s3.cmp &&
		(32'(side_s3.pixel_index) < MAX_SOURCE_PIXELS);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_a_q[AW'(side_s3.pixel_index)] <= side_s3.rgb;
			mem_b_q[AW'(side_s3.pixel_index)] <= side_s3.rgb;
		end
	end

	// Stage 4: registered reads of the four neighbours.
	bilr_pkg::side_t side_s4;
	logic [PXW-1:0]  pix_s4 [4];
	logic [3:0]      over_s4;
	logic [WW-1:0]   wgt_s4 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s4[0] <= mem_a_q[addr_s3[0]];
			pix_s4[1] <= mem_a_q[addr_s3[1]];
			pix_s4[2] <= mem_b_q[addr_s3[2]];
			pix_s4[3] <= mem_b_q[addr_s3[3]];
			over_s4   <= over_s3;
			wgt_s4    <= wgt_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else if (adv) begin
			side_s4 <= side_s3;
		end
	end

	// Stage 5: per-channel products. A clamped neighbour reads the blue byte of
	// the last pixel on every channel.
	bilr_pkg::side_t side_s5;
	logic [PW-1:0]   prod_s5 [3][4];
	logic [7:0]      chan [3][4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int c = 0; c < 3; c++) begin
				chan[c][k] = over_s4[k] ? pix_s4[k][7:0] : pix_s4[k][PXW-1-8*c -: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 4; k++) begin
					prod_s5[c][k] <= chan[c][k] * wgt_s4[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else if (adv) begin
			side_s5 <= side_s4;
		end
	end

	// Stage 6: sum the four products, truncate to a byte; this is the output register.
	logic           vld_s6;
	logic [ACW-1:0] acc [3];
	logic [7:0]     res [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc[c] = ACW'(prod_s5[c][0]) + ACW'(prod_s5[c][1]) +
				ACW'(prod_s5[c][2]) + ACW'(prod_s5[c][3]);
			res[c] = side_s5.bad ? 8'd0 : acc[c][ACW-1 -: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= side_s5.vld && side_s5.cmp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.out_red     <= res[0];
			out_data.out_green   <= res[1];
			out_data.out_blue    <= res[2];
			out_data.bad_request <= side_s5.bad;
		end
	end

	assign out_valid = vld_s6;

endmodule

// ----- hdl/bilr_div_pipe.sv -----
// Pipelined restoring divider for both sample axes, one quotient bit per stage.
// Depends on bilr_pkg for widths and the side-band struct.
module bilr_div_pipe #(
	parameter int INT_BITS  = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [bilr_pkg::NUM_W-1:0] num_x,
	input  logic [bilr_pkg::NUM_W-1:0] num_y,
	input  logic [bilr_pkg::TGT_W-1:0] den_x,
	input  logic [bilr_pkg::TGT_W-1:0] den_y,
	input  bilr_pkg::side_t           side_in,
	output bilr_pkg::side_t           side_out,
	output logic [INT_BITS+FRAC_BITS-1:0] quo_x,
	output logic [INT_BITS+FRAC_BITS-1:0] quo_y
);

	localparam int QW = INT_BITS + FRAC_BITS;
	localparam int DW = bilr_pkg::TGT_W;

	function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
		input logic [DW-1:0] d);
		logic [DW:0] t;
		logic [DW:0] diff;
		t = {r, b};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			div_step = {1'b1, diff[DW-1:0]};
		end else begin
			div_step = {1'b0, t[DW-1:0]};
		end
	endfunction

	logic [DW-1:0]   rx_s [QW+1];
	logic [DW-1:0]   ry_s [QW+1];
	logic [QW-1:0]   ex_s [QW+1];
	logic [QW-1:0]   ey_s [QW+1];
	logic [QW-1:0]   qx_s [QW+1];
	logic [QW-1:0]   qy_s [QW+1];
	bilr_pkg::side_t sd_s [QW+1];

	// The remainder starts from the high part of the dividend, which is below the
	// divisor for any request inside the target; the rest is shifted in bit by bit.
	assign rx_s[0] = DW'(num_x >> INT_BITS);
	assign ry_s[0] = DW'(num_y >> INT_BITS);
	assign ex_s[0] = {num_x[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
	assign ey_s[0] = {num_y[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;
	assign sd_s[0] = side_in;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW:0] nx;
		logic [DW:0] ny;
		assign nx = div_step(rx_s[i], ex_s[i][QW-1-i], den_x);
		assign ny = div_step(ry_s[i], ey_s[i][QW-1-i], den_y);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd_s[i+1] <= '0;
			end else if (adv) begin
				sd_s[i+1] <= sd_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rx_s[i+1] <= nx[DW-1:0];
				ry_s[i+1] <= ny[DW-1:0];
				ex_s[i+1] <= ex_s[i];
				ey_s[i+1] <= ey_s[i];
				qx_s[i+1] <= {qx_s[i][QW-2:0], nx[DW]};
				qy_s[i+1] <= {qy_s[i][QW-2:0], ny[DW]};
			end
		end
	end

	assign side_out = sd_s[QW];
	assign quo_x    = qx_s[QW];
	assign quo_y    = qy_s[QW];

endmodule

// ----- hdl/bilr_checker.sv -----
// Port-level checks of the resampler, bound to its top level.
// Depends on bilr_pkg and the assertion macros header.
`include "rgb_bilinear_resampler_macros.svh"

module bilr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input bilr_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input bilr_pkg::out_item_t out_data
);

	// A stalled result stays offered and unchanged.
	`BILR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "output transfer changed while stalled")

	// The input only stalls when a finished result is held up at the output.
	`BILR_ASSERT_IMP(a_in_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

	// A request outside the target carries zero colors.
	`BILR_ASSERT_IMP(a_bad_zero, clk, arst_n, out_valid && out_data.bad_request, out_data.out_red == 8'd0 && out_data.out_green == 8'd0 && out_data.out_blue == 8'd0, "bad request with nonzero color")

endmodule

bind rgb_bilinear_resampler bilr_checker u_bilr_checker (.*);
